// ===== rtl/dcf_pkg.sv =====
// Shared types, constants and the rounding function of the decimating complex FIR.
package dcf_pkg;

    localparam int TAPS   = 64;
    localparam int DATA_W = 16;
    localparam int FRAC_W = 15;
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + 2 + $clog2(TAPS);
    localparam int CNT_W  = $clog2(TAPS);
    localparam int SEL_W  = 8;
    localparam int FAC_W  = 9;
    localparam int DEC_W  = 8;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    localparam logic [FAC_W-1:0] FAC_MIN = FAC_W'(1);
    localparam logic [FAC_W-1:0] FAC_MAX = FAC_W'(256);

    localparam logic signed [ACC_W:0] ROUND_HALF = (ACC_W+1)'(2 ** (FRAC_W - 1));
    localparam logic signed [ACC_W:0] Q_MAX      = (ACC_W+1)'(32767);
    localparam logic signed [ACC_W:0] Q_MIN      = (ACC_W+1)'(-32768);

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
    } cplx_t;

    typedef struct packed {
        logic shift;
        logic rotate;
    } cell_ctrl_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     sat;
    } rnd_t;

    function automatic rnd_t round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0] biased;
        logic signed [ACC_W:0] q;
        rnd_t                  r;
        biased = (ACC_W+1)'(acc) + ROUND_HALF;
        q      = biased >>> FRAC_W;
        if (q > Q_MAX)
        begin
            r.val = DATA_W'(Q_MAX);
            r.sat = 1'b1;
        end
        else if (q < Q_MIN)
        begin
            r.val = DATA_W'(Q_MIN);
            r.sat = 1'b1;
        end
        else
        begin
            r.val = q[DATA_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/dcf_cell.sv =====
// One cell of the filter chain: one delay-line sample and one tap coefficient.
module dcf_cell
    import dcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       load_en,
    input  cplx_t      load_tap,
    input  cplx_t      prev_sample,
    input  cplx_t      next_sample,
    input  cplx_t      next_tap,
    output cplx_t      sample,
    output cplx_t      tap
);

    cplx_t sample_reg, sample_next;
    cplx_t tap_reg, tap_next;

    always_comb
    begin
        sample_next = sample_reg;
        tap_next    = tap_reg;
        if (ctrl.shift)
            sample_next = prev_sample;
        else if (ctrl.rotate)
            sample_next = next_sample;
        if (ctrl.rotate)
            tap_next = next_tap;
        else if (load_en)
            tap_next = load_tap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            tap_reg    <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
            tap_reg    <= tap_next;
        end
    end

    assign sample = sample_reg;
    assign tap    = tap_reg;

endmodule

// ===== rtl/dcf_mac.sv =====
// Complex multiply-accumulate unit fed from the head of the cell chain.
module dcf_mac
    import dcf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    clr,
    input  cplx_t                   sample,
    input  cplx_t                   tap,
    output logic signed [ACC_W-1:0] acc_re,
    output logic signed [ACC_W-1:0] acc_im
);

    logic signed [PROD_W-1:0] rr_reg, ii_reg, ri_reg, ir_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_re_next;
    logic signed [ACC_W-1:0]  acc_im_reg, acc_im_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rr_reg <= sample.re * tap.re;
            ii_reg <= sample.im * tap.im;
            ri_reg <= sample.re * tap.im;
            ir_reg <= sample.im * tap.re;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_vld_reg <= 1'b0;
        else
            prod_vld_reg <= en && !clr;
    end

    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (clr)
        begin
            acc_re_next = '0;
            acc_im_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_re_next = acc_re_reg + ACC_W'(rr_reg) - ACC_W'(ii_reg);
            acc_im_next = acc_im_reg + ACC_W'(ri_reg) + ACC_W'(ir_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
    end

    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;

endmodule

// ===== rtl/decimating_complex_fir.sv =====
// Decimating complex FIR: a ring of sample/tap cells rotated past one shared MAC.
// An output goes valid once the sample that fires it has passed through S_RUN, S_DRAIN and S_ROUND.
// Tap loads and non-firing samples are accepted back to back; a firing sample holds in_ready
// low while the cell ring rotates past the single MAC and until the output register is free.
// Reset (rst_n, async): delay line and taps zero, counter zero, factor 1, output empty.
module decimating_complex_fir
    import dcf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [FAC_W-1:0]         cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     opcode,
    input  logic signed [DATA_W-1:0] sample_re,
    input  logic signed [DATA_W-1:0] sample_im,
    input  logic [5:0]               tap_index,
    input  logic signed [DATA_W-1:0] tap_re,
    input  logic signed [DATA_W-1:0] tap_im,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] out_re,
    output logic signed [DATA_W-1:0] out_im,
    output logic                     saturated
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_ROUND = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   rot_cnt_reg, rot_cnt_next;
    logic [DEC_W-1:0]   dec_cnt_reg, dec_cnt_next;
    logic [FAC_W-1:0]   factor_reg, factor_next;
    logic [FAC_W-1:0]   fac_eff;
    logic [FAC_W-1:0]   dec_cnt_inc;
    logic               in_accept, smp_accept, fire;
    logic               out_free, out_load;
    logic               out_valid_reg, out_valid_next;
    cplx_t              out_data_reg;
    logic               out_sat_reg;
    rnd_t               rnd_re, rnd_im;
    cell_ctrl_t         cell_ctrl;
    cplx_t              new_sample, new_tap;
    cplx_t              cell_sample [TAPS];
    cplx_t              cell_tap    [TAPS];
    logic signed [ACC_W-1:0] acc_re, acc_im;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign smp_accept = in_accept && (opcode == OP_SAMPLE);

    always_comb
    begin
        if (factor_reg == '0)
            fac_eff = FAC_MIN;
        else if (factor_reg > FAC_MAX)
            fac_eff = FAC_MAX;
        else
            fac_eff = factor_reg;
    end

    assign dec_cnt_inc = FAC_W'(dec_cnt_reg) + FAC_W'(1);
    assign fire        = dec_cnt_inc >= fac_eff;

    assign factor_next  = cfg_wr_en ? cfg_wr_data : factor_reg;
    assign dec_cnt_next = !smp_accept ? dec_cnt_reg :
                          fire        ? '0 : dec_cnt_inc[DEC_W-1:0];

    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (state_reg == S_ROUND) && out_free;

    always_comb
    begin
        state_next   = state_reg;
        rot_cnt_next = rot_cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                rot_cnt_next = '0;
                if (smp_accept && fire)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                rot_cnt_next = rot_cnt_reg + CNT_W'(1);
                if (rot_cnt_reg == CNT_W'(TAPS - 1))
                    state_next = S_DRAIN;
            end
            S_DRAIN:
                state_next = S_ROUND;
            S_ROUND:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rot_cnt_reg   <= '0;
            dec_cnt_reg   <= '0;
            factor_reg    <= FAC_MIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rot_cnt_reg   <= rot_cnt_next;
            dec_cnt_reg   <= dec_cnt_next;
            factor_reg    <= factor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rnd_re = round_sat(acc_re);
    assign rnd_im = round_sat(acc_im);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.re <= rnd_re.val;
            out_data_reg.im <= rnd_im.val;
            out_sat_reg     <= rnd_re.sat || rnd_im.sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_re    = out_data_reg.re;
    assign out_im    = out_data_reg.im;
    assign saturated = out_sat_reg;

    assign new_sample.re = sample_re;
    assign new_sample.im = sample_im;
    assign new_tap.re    = tap_re;
    assign new_tap.im    = tap_im;

    assign cell_ctrl.shift  = smp_accept;
    assign cell_ctrl.rotate = (state_reg == S_RUN);

    for (genvar i = 0; i < TAPS; i++)
    begin : g_cell
        logic tap_load;
        assign tap_load = in_accept && (opcode == OP_LOAD)
                          && (SEL_W'(tap_index) == SEL_W'(i));
        dcf_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .load_en     (tap_load),
            .load_tap    (new_tap),
            .prev_sample ((i == 0) ? new_sample : cell_sample[(i + TAPS - 1) % TAPS]),
            .next_sample (cell_sample[(i + 1) % TAPS]),
            .next_tap    (cell_tap[(i + 1) % TAPS]),
            .sample      (cell_sample[i]),
            .tap         (cell_tap[i])
        );
    end

    dcf_mac u_mac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (state_reg == S_RUN),
        .clr    (smp_accept && fire),
        .sample (cell_sample[0]),
        .tap    (cell_tap[0]),
        .acc_re (acc_re),
        .acc_im (acc_im)
    );

endmodule

// ===== test/dcf_checker.sv =====
// Checker for the decimating complex FIR: predicts each filter output and compares it.
module dcf_checker
    import dcf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [FAC_W-1:0]         cfg_wr_data,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic                     opcode,
    input  logic signed [DATA_W-1:0] sample_re,
    input  logic signed [DATA_W-1:0] sample_im,
    input  logic [5:0]               tap_index,
    input  logic signed [DATA_W-1:0] tap_re,
    input  logic signed [DATA_W-1:0] tap_im,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [DATA_W-1:0] out_re,
    input  logic signed [DATA_W-1:0] out_im,
    input  logic                     saturated,
    output int                       mismatches,
    output int                       outstanding,
    output int                       items_seen,
    output int                       loads_seen,
    output int                       outputs_seen,
    output int                       clipped_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic                     sat;
    } fir_out_t;

    cplx_t            history [TAPS];
    cplx_t            coef    [TAPS];
    logic [CNT_W-1:0] newest;
    logic [DEC_W-1:0] dec_count;
    logic [FAC_W-1:0] factor;
    fir_out_t         filtered_q [$];

    function automatic logic signed [DATA_W-1:0] round_q15(input longint acc, inout bit clipped);
        longint q;
        q = (acc + 64'sd16384) >>> FRAC_W;
        if (q > 32767)
        begin
            clipped = 1'b1;
            return 16'sh7fff;
        end
        if (q < -32768)
        begin
            clipped = 1'b1;
            return 16'sh8000;
        end
        return DATA_W'(q);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        fir_out_t want;
        int       eff;
        int       k;
        longint   acc_re;
        longint   acc_im;
        bit       clipped;
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                history[i] = '0;
                coef[i]    = '0;
            end
            newest       = '0;
            dec_count    = '0;
            factor       = FAC_MIN;
            filtered_q   = {};
            mismatches   = 0;
            outstanding  = 0;
            items_seen   = 0;
            loads_seen   = 0;
            outputs_seen = 0;
            clipped_seen = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                outputs_seen++;
                if (saturated)
                    clipped_seen++;
                if (filtered_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: output with nothing expected: re=%0d im=%0d sat=%0b",
                                 $time, out_re, out_im, saturated);
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (out_re !== want.re || out_im !== want.im || saturated !== want.sat)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected re=%0d im=%0d sat=%0b, actual re=%0d im=%0d sat=%0b",
                                     $time, want.re, want.im, want.sat,
                                     out_re, out_im, saturated);
                    end
                end
            end

            if (cfg_wr_en)
                factor = cfg_wr_data;

            if (in_valid && in_ready)
            begin
                items_seen++;
                if (opcode == OP_LOAD)
                begin
                    loads_seen++;
                    if (int'(tap_index) < TAPS)
                        coef[tap_index] = '{re: tap_re, im: tap_im};
                end
                else
                begin
                    eff = (factor == '0) ? int'(FAC_MIN) :
                          (factor > FAC_MAX) ? int'(FAC_MAX) : int'(factor);
                    history[newest] = '{re: sample_re, im: sample_im};
                    if (int'(dec_count) + 1 < eff)
                        dec_count = dec_count + 1'b1;
                    else
                    begin
                        dec_count = '0;
                        acc_re    = 0;
                        acc_im    = 0;
                        for (int i = 0; i < TAPS; i++)
                        begin
                            k = (int'(newest) + TAPS - i) % TAPS;
                            acc_re += longint'(history[k].re) * longint'(coef[i].re)
                                    - longint'(history[k].im) * longint'(coef[i].im);
                            acc_im += longint'(history[k].re) * longint'(coef[i].im)
                                    + longint'(history[k].im) * longint'(coef[i].re);
                        end
                        clipped = 1'b0;
                        want.re  = round_q15(acc_re, clipped);
                        want.im  = round_q15(acc_im, clipped);
                        want.sat = clipped;
                        filtered_q.push_back(want);
                    end
                    newest = CNT_W'((int'(newest) + 1) % TAPS);
                end
            end
            outstanding = filtered_q.size();
        end
    end

endmodule

// ===== test/tb_decimating_complex_fir.sv =====
// Testbench top for the decimating complex FIR: stimulus, idling, pressure and verdict.
module tb_decimating_complex_fir
    import dcf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [FAC_W-1:0]         cfg_wr_data;
    logic                     in_valid;
    logic                     in_ready;
    logic                     opcode;
    logic signed [DATA_W-1:0] sample_re;
    logic signed [DATA_W-1:0] sample_im;
    logic [5:0]               tap_index;
    logic signed [DATA_W-1:0] tap_re;
    logic signed [DATA_W-1:0] tap_im;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] out_re;
    logic signed [DATA_W-1:0] out_im;
    logic                     saturated;

    int mismatches;
    int outstanding;
    int items_seen;
    int loads_seen;
    int outputs_seen;
    int clipped_seen;
    int tx_idle_pct;
    int rx_stall_pct;
    bit long_hold;

    decimating_complex_fir dut (.*);
    dcf_checker            checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
            end
            out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    task automatic offer(input logic op,
                         input logic signed [DATA_W-1:0] s_re,
                         input logic signed [DATA_W-1:0] s_im,
                         input logic [5:0] idx,
                         input logic signed [DATA_W-1:0] t_re,
                         input logic signed [DATA_W-1:0] t_im);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        sample_re <= s_re;
        sample_im <= s_im;
        tap_index <= idx;
        tap_re    <= t_re;
        tap_im    <= t_im;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (TAPS + 8) @(posedge clk);
    endtask

    task automatic set_factor(input logic [FAC_W-1:0] f);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= f;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic signed [DATA_W-1:0] rand_value(input int small_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            unique case ($urandom_range(0, 3))
                0:       return 16'sh8000;
                1:       return 16'sh7fff;
                2:       return 16'sh0000;
                default: return 16'shffff;
            endcase
        end
        if (roll < 10 + small_pct)
            return DATA_W'(int'($urandom_range(0, 1023)) - 512);
        return DATA_W'($urandom);
    endfunction

    task automatic random_item();
        logic op;
        op = ($urandom_range(0, 99) < 20) ? OP_LOAD : OP_SAMPLE;
        offer(op, rand_value(0), rand_value(0), 6'($urandom), rand_value(60), rand_value(60));
    endtask

    task automatic run_phase(input logic [FAC_W-1:0] f, input int tx_pct, input int rx_pct,
                             input int n);
        set_factor(f);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (n) random_item();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        opcode       = OP_SAMPLE;
        sample_re    = '0;
        sample_im    = '0;
        tap_index    = '0;
        tap_re       = '0;
        tap_im       = '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        long_hold    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(OP_LOAD,   16'sh0000, 16'sh0000, 6'd0,  16'sh8000, 16'sh8000);
        offer(OP_SAMPLE, 16'sh8000, 16'sh8000, 6'd0,  16'sh0000, 16'sh0000);
        offer(OP_LOAD,   16'sh0000, 16'sh0000, 6'd0,  16'sh4000, 16'sh0000);
        offer(OP_SAMPLE, 16'sh0001, 16'shffff, 6'd63, 16'sh7fff, 16'sh7fff);
        offer(OP_LOAD,   16'sh7fff, 16'sh8000, 6'd63, 16'sh7fff, 16'sh7fff);
        offer(OP_SAMPLE, 16'sh7fff, 16'sh8000, 6'd63, 16'sh8000, 16'sh7fff);
        offer(OP_SAMPLE, 16'shffff, 16'sh0000, 6'd0,  16'sh0000, 16'sh0000);
        offer(OP_LOAD,   16'sh0000, 16'sh0000, 6'd1,  16'sh8000, 16'sh7fff);
        offer(OP_SAMPLE, 16'sh0000, 16'sh0000, 6'd0,  16'sh0000, 16'sh0000);
        set_factor('0);
        repeat (3) offer(OP_SAMPLE, rand_value(0), rand_value(0), 6'd0, 16'sh0000, 16'sh0000);
        set_factor(9'd8);
        repeat (5) offer(OP_SAMPLE, rand_value(0), rand_value(0), 6'd0, 16'sh0000, 16'sh0000);
        set_factor(9'd3);
        repeat (3) offer(OP_SAMPLE, rand_value(0), rand_value(0), 6'd0, 16'sh0000, 16'sh0000);

        run_phase(9'd1,   0,  0,  170);
        run_phase(9'd1,   59, 0,  150);
        run_phase(9'd2,   0,  59, 150);
        run_phase(9'd1,   13, 13, 150);
        run_phase(9'd3,   0,  0,  100);
        run_phase(9'd256, 0,  0,  80);
        run_phase(9'd300, 59, 0,  40);
        run_phase(9'd7,   13, 13, 100);
        run_phase(9'd511, 0,  0,  60);

        set_factor(9'd1);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        long_hold    = 1'b1;
        repeat (40) random_item();
        drain();

        $display("Covered %0d transactions (%0d tap loads), %0d filter outputs, %0d clipped,",
                 items_seen, loads_seen, outputs_seen, clipped_seen);
        $display("across decimation settings 0 to 511 with idle, stall and back-pressure mixes.");
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
